@@ rtl/afq_pkg.sv @@
// shared types, constants and helper function of the affine float quantizer
`default_nettype none

package afq_pkg;

   // pipeline depth, stage 1 takes the input beat and the last stage is the output register
   localparam int unsigned NUM_STAGES = 10;

   // configuration register indexes
   localparam logic [1:0] CSR_INV_SCALE   = 2'd0;
   localparam logic [1:0] CSR_SCALE_ZERO  = 2'd1;
   localparam logic [1:0] CSR_OFFSET      = 2'd2;
   localparam logic [1:0] CSR_TARGET_TYPE = 2'd3;

   localparam logic [63:0] INV_SCALE_RESET = 64'h3FF0_0000_0000_0000;

   // fixed point sum: lsb weight is 2^-FRAC_BITS
   localparam int unsigned FRAC_BITS = 66;

   typedef enum logic [1:0] {
      KIND_NORM,   // finite product, value follows the datapath
      KIND_ZP,     // product is zero, sum is the zero point
      KIND_SAT,    // magnitude far out of range, saturate by sign
      KIND_ZERO    // nan input or inf times zero, result is zero
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     sign;
      logic     err;
   } tag_type;

   typedef struct packed {
      logic [63:0]        inv_scale;
      logic               scale_is_zero;
      logic signed [31:0] offset;
      logic               target_type;
   } cfg_type;

   // leading zero count of a left aligned word, 127 for an all zero word
   function automatic logic [6:0] lead_zeros(input logic [127:0] x);
      logic [6:0] n;
      n = 7'd127;
      for (int i = 0; i < 128; i++) begin
         if (x[i]) n = 7'(127 - i);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

@@ rtl/afq_if.sv @@
// valid/ready channel interfaces for input and result beats
`default_nettype none

interface afq_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value_bits;

   modport source (output valid, output value_bits, input ready);
   modport sink   (input valid, input value_bits, output ready);
endinterface

interface afq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] quantized_value;
   logic               value_error;

   modport source (output valid, output quantized_value, output value_error, input ready);
   modport sink   (input valid, input quantized_value, input value_error, output ready);
endinterface

`default_nettype wire

@@ rtl/afq_unpack.sv @@
// stage 1: operand decode, subnormal normalization and special case classification
`default_nettype none

module afq_unpack
   import afq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [31:0]        value_bits,
   input  wire cfg_type            cfg,
   output      logic [52:0]        ma_ff,
   output      logic signed [12:0] ea_ff,
   output      logic [23:0]        mb_ff,
   output      logic signed [12:0] eb_ff,
   output      tag_type            tag_ff
);

   logic [10:0]        exp_d;
   logic [51:0]        frac_d;
   logic [7:0]         exp_f;
   logic [22:0]        frac_f;
   logic [6:0]         lz_d;
   logic [6:0]         lz_f;
   logic               d_zero, d_inf, d_nan;
   logic               f_zero, f_inf, f_nan;
   logic [52:0]        ma_in;
   logic signed [12:0] ea_in;
   logic [23:0]        mb_in;
   logic signed [12:0] eb_in;
   tag_type            tag_in;

   // field split and classes
   always_comb begin
      exp_d  = cfg.inv_scale[62:52];
      frac_d = cfg.inv_scale[51:0];
      exp_f  = value_bits[30:23];
      frac_f = value_bits[22:0];
      d_zero = (exp_d == 11'd0) && (frac_d == 52'd0);
      d_inf  = (exp_d == 11'h7FF) && (frac_d == 52'd0);
      d_nan  = (exp_d == 11'h7FF) && (frac_d != 52'd0);
      f_zero = (exp_f == 8'd0) && (frac_f == 23'd0);
      f_inf  = (exp_f == 8'hFF) && (frac_f == 23'd0);
      f_nan  = (exp_f == 8'hFF) && (frac_f != 23'd0);
      lz_d   = lead_zeros({1'b0, frac_d, 75'd0});
      lz_f   = lead_zeros({1'b0, frac_f, 104'd0});
   end

   // normalized significands with unbiased exponents
   always_comb begin
      if (exp_d == 11'd0) begin
         ma_in = 53'({1'b0, frac_d} << lz_d);
         ea_in = -13'sd1022 - $signed({6'd0, lz_d});
      end else begin
         ma_in = {1'b1, frac_d};
         ea_in = $signed({2'b00, exp_d}) - 13'sd1023;
      end
      if (exp_f == 8'd0) begin
         mb_in = 24'({1'b0, frac_f} << lz_f);
         eb_in = -13'sd126 - $signed({6'd0, lz_f});
      end else begin
         mb_in = {1'b1, frac_f};
         eb_in = $signed({5'd0, exp_f}) - 13'sd127;
      end
   end

   // special case selection
   always_comb begin
      tag_in.sign = cfg.inv_scale[63] ^ value_bits[31];
      tag_in.err  = 1'b0;
      priority if (f_nan) begin
         tag_in.kind = KIND_ZERO;
         tag_in.err  = 1'b1;
      end else if (cfg.scale_is_zero) begin
         tag_in.kind = KIND_ZP;
         tag_in.err  = !f_zero;
      end else if (d_nan || (d_inf && f_zero) || (f_inf && d_zero)) begin
         tag_in.kind = KIND_ZERO;
      end else if (d_inf || f_inf) begin
         tag_in.kind = KIND_SAT;
      end else if (d_zero || f_zero) begin
         tag_in.kind = KIND_ZP;
      end else begin
         tag_in.kind = KIND_NORM;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff  <= ma_in;
         ea_ff  <= ea_in;
         mb_ff  <= mb_in;
         eb_ff  <= eb_in;
         tag_ff <= tag_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/afq_mul.sv @@
// stages 2-4: split significand product, partial product merge, rounding to double
`default_nettype none

module afq_mul
   import afq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [2:0]         en,
   input  wire logic [52:0]        ma,
   input  wire logic signed [12:0] ea,
   input  wire logic [23:0]        mb,
   input  wire logic signed [12:0] eb,
   input  wire tag_type            tag,
   output      logic [52:0]        m_ff,
   output      logic signed [12:0] e_ff,
   output      tag_type            tag_ff
);

   logic [50:0]        pa_ff;
   logic [49:0]        pb_ff;
   logic signed [12:0] e2_ff;
   tag_type            tag2_ff;
   logic [76:0]        p_ff;
   logic signed [12:0] e3_ff;
   tag_type            tag3_ff;

   logic               hi;
   logic [52:0]        m_pre;
   logic               guard, sticky, rup;
   logic [53:0]        m_sum;
   logic [52:0]        m_in;
   logic signed [12:0] e_in;

   // two partial products of the significands
   always_ff @(posedge clock) begin
      if (en[0]) begin
         pa_ff   <= 51'(ma[52:26]) * 51'(mb);
         pb_ff   <= 50'(ma[25:0]) * 50'(mb);
         e2_ff   <= ea + eb;
         tag2_ff <= tag;
      end
   end

   // merge into the full product
   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_ff    <= (77'(pa_ff) << 26) + 77'(pb_ff);
         e3_ff   <= e2_ff;
         tag3_ff <= tag2_ff;
      end
   end

   // round to nearest even on 53 bits
   always_comb begin
      hi     = p_ff[76];
      m_pre  = hi ? p_ff[76:24] : p_ff[75:23];
      guard  = hi ? p_ff[23] : p_ff[22];
      sticky = hi ? (|p_ff[22:0]) : (|p_ff[21:0]);
      rup    = guard && (sticky || m_pre[0]);
      m_sum  = {1'b0, m_pre} + 54'(rup);
      m_in   = m_sum[53] ? m_sum[53:1] : m_sum[52:0];
      e_in   = e3_ff + $signed({12'd0, hi}) + $signed({12'd0, m_sum[53]});
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         m_ff   <= m_in;
         e_ff   <= e_in;
         tag_ff <= tag3_ff;
      end
   end

endmodule

`default_nettype wire

@@ rtl/afq_sum.sv @@
// stages 5-8: fixed point alignment, zero point add, magnitude and leading zero count
`default_nettype none

module afq_sum
   import afq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [3:0]         en,
   input  wire logic [52:0]        m,
   input  wire logic signed [12:0] e,
   input  wire tag_type            tag,
   input  wire logic signed [31:0] offset,
   output      logic [101:0]       a_ff,
   output      logic [6:0]         lz_ff,
   output      tag_type            tag_ff
);

   logic [101:0]       pf_ff;
   tag_type            tag5_ff;
   logic [102:0]       s_ff;
   tag_type            tag6_ff;
   logic [101:0]       a7_ff;
   tag_type            tag7_ff;

   logic signed [12:0] sh_full;
   logic [154:0]       shifted;
   logic [101:0]       pf_in;
   tag_type            tag5_in;
   logic [102:0]       pf_ext;
   tag_type            tag7_in;

   // place the product on the fixed point grid, dropped bits fold into a sticky lsb
   always_comb begin
      sh_full = e + 13'sd67;
      shifted = 155'(m) << sh_full[6:0];
      pf_in   = {shifted[154:54], |shifted[53:0]};
      tag5_in = tag;
      unique case (tag.kind)
         KIND_NORM: begin
            if (e > 13'sd33) begin
               tag5_in.kind = KIND_SAT;
            end else if (e < -13'sd66) begin
               pf_in = '0;
            end
         end
         KIND_ZP: begin
            pf_in        = '0;
            tag5_in.kind = KIND_NORM;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pf_ff   <= pf_in;
         tag5_ff <= tag5_in;
      end
   end

   // signed sum with the zero point
   always_comb begin
      pf_ext = tag5_ff.sign ? (103'd0 - {1'b0, pf_ff}) : {1'b0, pf_ff};
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s_ff    <= {{5{offset[31]}}, offset, 66'd0} + pf_ext;
         tag6_ff <= tag5_ff;
      end
   end

   // sign and magnitude
   always_comb begin
      tag7_in = tag6_ff;
      if (tag6_ff.kind == KIND_NORM) tag7_in.sign = s_ff[102];
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         a7_ff   <= s_ff[102] ? 102'(103'd0 - s_ff) : s_ff[101:0];
         tag7_ff <= tag7_in;
      end
   end

   // leading zero count of the magnitude
   always_ff @(posedge clock) begin
      if (en[3]) begin
         a_ff   <= a7_ff;
         lz_ff  <= lead_zeros({a7_ff, 26'd0});
         tag_ff <= tag7_ff;
      end
   end

endmodule

`default_nettype wire

@@ rtl/afq_round.sv @@
// stages 9-10: round to double, round half away to integer, saturate and clamp
`default_nettype none

module afq_round
   import afq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [1:0]         en,
   input  wire logic [101:0]       a,
   input  wire logic [6:0]         lz,
   input  wire tag_type            tag,
   input  wire logic               target_type,
   output      logic signed [31:0] q_ff,
   output      logic               err_ff
);

   localparam logic [36:0] MAG_MIN = 37'h0_8000_0000;
   localparam logic [36:0] MAG_MAX = 37'h0_7FFF_FFFF;

   logic [36:0]        qmag_ff;
   tag_type            tag9_ff;

   logic signed [7:0]  p;
   logic [6:0]         u;
   logic [101:0]       mask_u;
   logic               guard, sticky, lsb, rup;
   logic [101:0]       d;
   logic [36:0]        qmag_in;
   logic signed [31:0] q_sat;
   logic signed [31:0] q_in;

   // round the magnitude at its 53rd significant bit, then half away from zero
   always_comb begin
      p       = 8'sd101 - $signed({1'b0, lz});
      u       = 7'(p - 8'sd52);
      mask_u  = (102'd1 << u) - 102'd1;
      guard   = a[u - 7'd1];
      sticky  = |(a & (mask_u >> 1));
      lsb     = a[u];
      rup     = guard && (sticky || lsb);
      d       = (a & ~mask_u) + (rup ? (102'd1 << u) : 102'd0);
      qmag_in = 37'(d[101:FRAC_BITS]) + 37'(d[FRAC_BITS-1]);
      if (p < 8'sd53) qmag_in = '0;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         qmag_ff <= qmag_in;
         tag9_ff <= tag;
      end
   end

   // int32 saturation then target range
   always_comb begin
      if (tag9_ff.sign) begin
         q_sat = (qmag_ff > MAG_MIN) ? 32'sh8000_0000 : 32'(37'd0 - qmag_ff);
      end else begin
         q_sat = (qmag_ff > MAG_MAX) ? 32'sh7FFF_FFFF : qmag_ff[31:0];
      end
      unique case (tag9_ff.kind)
         KIND_ZERO: q_in = '0;
         KIND_SAT:  q_in = tag9_ff.sign ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         default:   q_in = q_sat;
      endcase
      if (!target_type) begin
         if (q_in < 32'sd0) begin
            q_in = '0;
         end else if (q_in > 32'sd255) begin
            q_in = 32'sd255;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         q_ff   <= q_in;
         err_ff <= tag9_ff.err;
      end
   end

endmodule

`default_nettype wire

@@ rtl/affine_float_quantizer_core.sv @@
// top level of the affine float quantizer: csr block, stage control, datapath
//
//  channel   dir  handshake          payload
//  req_chan  in   valid/ready        value_bits[31:0] (ieee single)
//  rsp_chan  out  valid/ready        quantized_value[31:0] signed, value_error
//  csr_*     in   csr_we             csr_index[1:0], csr_wdata[63:0]
//
// ten register stages; the accepting edge loads stage 1 and the beat then moves
// through stages 2 to 9 to the output register, where it is offered as a result;
// one beat can enter every cycle unless an output stall has filled the stages
// throughput is set by the stage chain: every stage moves when it is empty
// or the stage after it moves, so bubbles are squeezed out under a stall
// synchronous active high reset clears the valid bits and csr registers, but sets inv_scale to 1.0
`default_nettype none

module affine_float_quantizer_core
   import afq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   afq_req_if.sink          req_chan,
   afq_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   cfg_type                  cfg_ff;
   logic [NUM_STAGES:1]      v_ff;
   logic [NUM_STAGES:1]      en;

   logic [52:0]              ma;
   logic signed [12:0]       ea;
   logic [23:0]              mb;
   logic signed [12:0]       eb;
   tag_type                  tag1;
   logic [52:0]              m4;
   logic signed [12:0]       e4;
   tag_type                  tag4;
   logic [101:0]             a8;
   logic [6:0]               lz8;
   tag_type                  tag8;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_scale     <= INV_SCALE_RESET;
         cfg_ff.scale_is_zero <= 1'b0;
         cfg_ff.offset        <= '0;
         cfg_ff.target_type   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_SCALE:   cfg_ff.inv_scale     <= csr_wdata;
            CSR_SCALE_ZERO:  cfg_ff.scale_is_zero <= csr_wdata[0];
            CSR_OFFSET:      cfg_ff.offset        <= csr_wdata[31:0];
            CSR_TARGET_TYPE: cfg_ff.target_type   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage enables, each stage moves when empty or when its successor moves
   always_comb begin
      en[NUM_STAGES] = !v_ff[NUM_STAGES] || rsp_chan.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_chan.ready = en[1];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) v_ff[1] <= req_chan.valid;
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   afq_unpack u_unpack (
      .clock      (clock),
      .en         (en[1]),
      .value_bits (req_chan.value_bits),
      .cfg        (cfg_ff),
      .ma_ff      (ma),
      .ea_ff      (ea),
      .mb_ff      (mb),
      .eb_ff      (eb),
      .tag_ff     (tag1)
   );

   afq_mul u_mul (
      .clock  (clock),
      .en     (en[4:2]),
      .ma     (ma),
      .ea     (ea),
      .mb     (mb),
      .eb     (eb),
      .tag    (tag1),
      .m_ff   (m4),
      .e_ff   (e4),
      .tag_ff (tag4)
   );

   afq_sum u_sum (
      .clock      (clock),
      .en         (en[8:5]),
      .m          (m4),
      .e          (e4),
      .tag        (tag4),
      .offset     (cfg_ff.offset),
      .a_ff       (a8),
      .lz_ff      (lz8),
      .tag_ff     (tag8)
   );

   afq_round u_round (
      .clock       (clock),
      .en          (en[10:9]),
      .a           (a8),
      .lz          (lz8),
      .tag         (tag8),
      .target_type (cfg_ff.target_type),
      .q_ff        (rsp_chan.quantized_value),
      .err_ff      (rsp_chan.value_error)
   );

   assign rsp_chan.valid = v_ff[NUM_STAGES];

   // uint8 mode never leaves 0..255
   a_uint8_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !cfg_ff.target_type) |-> (rsp_chan.quantized_value[31:8] == 24'd0))
      else $error("uint8 result out of range");

   // with a live scale an error only comes from a nan, which gives zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.value_error && !cfg_ff.scale_is_zero)
      |-> (rsp_chan.quantized_value == 32'sd0))
      else $error("error beat with nonzero value");

   // under an output stall, input ready is high exactly when a bubble exists
   a_bubble_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> (req_chan.ready == !(&v_ff)))
      else $error("stall does not match pipeline occupancy");

   // an accepted beat occupies stage 1 next cycle
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> v_ff[1])
      else $error("accepted beat lost at stage 1");

endmodule

`default_nettype wire

@@ tb/sv/tb_affine_float_quantizer_core.sv @@
// testbench of the affine float quantizer: directed table, random phases, scoreboard
`timescale 1ns / 100ps

module tb_affine_float_quantizer_core;
   import afq_pkg::*;

   typedef struct {
      logic signed [31:0] qval;
      logic               err;
   } quant_result_type;

   typedef enum logic [1:0] {ROW_ITEM, ROW_ITEM_KNOWN, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [1:0]         index;
      logic [63:0]        wdata;
      logic [31:0]        value;
      logic signed [31:0] want_q;
      logic               want_err;
   } stim_row_type;

   localparam int          NUM_PHASES  = 12;
   localparam int          PHASE_ITEMS = 152;
   localparam int          STALL_LIMIT = 4000;
   localparam logic [63:0] DBL_NAN     = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] DBL_INF     = 64'h7FF0_0000_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   afq_req_if req_if ();
   afq_rsp_if rsp_if ();

   affine_float_quantizer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock, period 4 ns
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow copy of the csr registers
   logic [63:0]        inv_scale_q  = INV_SCALE_RESET;
   logic               scale_zero_q = 1'b0;
   logic signed [31:0] offset_q     = '0;
   logic               target_q     = 1'b0;

   quant_result_type pending_q[$];
   int  mismatches    = 0;
   bit  sender_idles  = 1'b1;
   bit  receiver_idles = 1'b1;
   bit  hold_request  = 1'b0;
   int  hold_count    = 0;
   int  quiet_cycles  = 0;

   // single precision bits widened to double precision bits, exact
   function automatic logic [63:0] single_to_double(input logic [31:0] f);
      logic [7:0]  e;
      logic [22:0] m;
      logic [51:0] frac;
      int          p;
      e = f[30:23];
      m = f[22:0];
      if (e == 8'hFF)
         return {f[31], 11'h7FF, m, 29'd0};
      if (e == 8'd0) begin
         if (m == '0)
            return {f[31], 63'd0};
         p = 0;
         for (int i = 0; i < 23; i++)
            if (m[i]) p = i;
         frac = 52'(m) << (52 - p);
         return {f[31], 11'(p - 149 + 1023), frac};
      end
      return {f[31], 11'(int'(e) - 127 + 1023), m, 29'd0};
   endfunction

   function automatic bit is_nan_double(input logic [63:0] d);
      return d[62:52] == 11'h7FF && d[51:0] != '0;
   endfunction

   // expected quantized value for one input beat under the current registers
   function automatic quant_result_type quantize(input logic [31:0] vb);
      quant_result_type r;
      real              s;
      real              frac;
      longint           whole;
      logic [63:0]      sbits;
      r.qval = '0;
      r.err  = 1'b0;
      if (vb[30:23] == 8'hFF && vb[22:0] != '0) begin
         r.err = 1'b1;
         return r;
      end
      if (scale_zero_q) begin
         r.err = vb[30:0] != '0;
         s = real'(offset_q);
      end else begin
         s = $bitstoreal(inv_scale_q) * $bitstoreal(single_to_double(vb));
         s = real'(offset_q) + s;
      end
      sbits = $realtobits(s);
      if (is_nan_double(sbits))
         return r;
      // round half away from zero, saturate to int32
      if (s >= 2147483647.5)
         whole = 64'sh7FFF_FFFF;
      else if (s <= -2147483648.5)
         whole = -64'sh8000_0000;
      else begin
         whole = longint'($rtoi(s));
         frac  = s - real'(whole);
         if (frac >= 0.5) whole++;
         else if (frac <= -0.5) whole--;
         if (whole > 64'sh7FFF_FFFF) whole = 64'sh7FFF_FFFF;
         if (whole < -64'sh8000_0000) whole = -64'sh8000_0000;
      end
      if (!target_q) begin
         if (whole < 0) whole = 0;
         if (whole > 255) whole = 255;
      end
      r.qval = 32'(whole);
      return r;
   endfunction

   // csr write, caller lowers the enable
   task automatic write_csr(input logic [1:0] idx, input logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_INV_SCALE:   inv_scale_q  = data;
         CSR_SCALE_ZERO:  scale_zero_q = data[0];
         CSR_OFFSET:      offset_q     = data[31:0];
         CSR_TARGET_TYPE: target_q     = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // offer one beat and hold it until accepted
   task automatic send_value(input logic [31:0] v, input bit known,
                             input quant_result_type want);
      quant_result_type e;
      e = known ? want : quantize(v);
      req_if.valid      <= 1'b1;
      req_if.value_bits <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_q.push_back(e);
      // idle cycles drawn one at a time
      while (sender_idles && $urandom_range(0, 99) < 31) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_single();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0, 1: ;
         2, 3, 4: v[30:23] = 8'($urandom_range(110, 160));
         5, 6: begin
            v[30:23] = 8'($urandom_range(126, 134));
            v[15:0]  = '0;
         end
         7: v[30:23] = 8'($urandom_range(0, 1) ? 8'hFF : 8'h00);
         8: v = {v[31], 31'd0};
         default: v[30:23] = 8'($urandom_range(140, 254));
      endcase
      return v;
   endfunction

   function automatic logic [63:0] random_inv_scale();
      logic [63:0] d;
      d = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0: d = INV_SCALE_RESET;
         1: d = '0;
         2: d = DBL_NAN;
         3: d = {d[63], DBL_INF[62:0]};
         4: ;
         default: d[62:52] = 11'($urandom_range(1010, 1040));
      endcase
      return d;
   endfunction

   function automatic logic [63:0] random_offset();
      logic [63:0] z;
      z = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: z[31:0] = 32'h7FFF_FFFF;
         1: z[31:0] = 32'h8000_0000;
         2: z[31:0] = '0;
         3: ;
         default: z[31:0] = 32'($urandom_range(0, 300)) - 32'd20;
      endcase
      return z;
   endfunction

   // directed table
   stim_row_type directed[$];

   function automatic stim_row_type item(input logic [31:0] v);
      stim_row_type r;
      r = '{ROW_ITEM, 2'd0, 64'd0, v, 32'sd0, 1'b0};
      return r;
   endfunction

   function automatic stim_row_type known(input logic [31:0] v, input logic signed [31:0] q,
                                          input logic e);
      stim_row_type r;
      r = '{ROW_ITEM_KNOWN, 2'd0, 64'd0, v, q, e};
      return r;
   endfunction

   function automatic stim_row_type csr(input logic [1:0] idx, input logic [63:0] d);
      stim_row_type r;
      r = '{ROW_CSR, idx, d, 32'd0, 32'sd0, 1'b0};
      return r;
   endfunction

   initial begin
      directed = '{
         known(32'h0000_0000, 0, 1'b0), known(32'h8000_0000, 0, 1'b0),
         known(32'h3F00_0000, 1, 1'b0), known(32'h3FC0_0000, 2, 1'b0),
         known(32'h437F_0000, 255, 1'b0), known(32'h4380_0000, 255, 1'b0),
         known(32'hBF80_0000, 0, 1'b0), known(32'h7F80_0000, 255, 1'b0),
         known(32'h7FC0_0000, 0, 1'b1), known(32'hFFFF_FFFF, 0, 1'b1),
         item(32'h0000_0001), known(32'h7F7F_FFFF, 255, 1'b0),
         csr(CSR_TARGET_TYPE, 64'hFFFF_FFFF_FFFF_FFFF),
         known(32'hFF80_0000, 32'sh8000_0000, 1'b0),
         known(32'h4F00_0000, 32'sh7FFF_FFFF, 1'b0),
         known(32'hCF00_0000, 32'sh8000_0000, 1'b0), known(32'hBFC0_0000, -2, 1'b0),
         item(32'h4B7F_FFFF),
         csr(CSR_OFFSET, 64'hABCD_0000_7FFF_FFFF),
         known(32'h3F80_0000, 32'sh7FFF_FFFF, 1'b0),
         csr(CSR_SCALE_ZERO, 64'd1), csr(CSR_OFFSET, -64'sd5),
         known(32'h8000_0000, -5, 1'b0), known(32'h3F80_0000, -5, 1'b1),
         known(32'h7FC0_0001, 0, 1'b1),
         csr(CSR_SCALE_ZERO, 64'd0), csr(CSR_OFFSET, 64'd0),
         csr(CSR_INV_SCALE, 64'd0),
         known(32'h7F80_0000, 0, 1'b0), item(32'h4120_0000),
         csr(CSR_INV_SCALE, DBL_NAN),
         known(32'h3F80_0000, 0, 1'b0)
      };
   end

   // result side: ready pattern with an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_count   <= 0;
      end else if (hold_request && hold_count == 0) begin
         rsp_if.ready <= 1'b0;
         hold_count   <= 300;
      end else if (hold_count > 1) begin
         hold_count <= hold_count - 1;
      end else begin
         hold_count   <= 0;
         rsp_if.ready <= !receiver_idles || $urandom_range(0, 99) >= 31;
      end
   end

   // scoreboard on accepted result beats
   always @(posedge clock) begin
      quant_result_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: q=%0d err=%0b",
                        rsp_if.quantized_value, rsp_if.value_error);
         end else begin
            e = pending_q.pop_front();
            if (rsp_if.quantized_value !== e.qval || rsp_if.value_error !== e.err) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected q=%0d err=%0b, got q=%0d err=%0b",
                           e.qval, e.err, rsp_if.quantized_value, rsp_if.value_error);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // stimulus
   initial begin
      quant_result_type want;
      bit               csr_open;
      req_if.valid      = 1'b0;
      req_if.value_bits = '0;
      csr_open = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            if (!csr_open) begin
               req_if.valid <= 1'b0;
               wait_drained();
            end
            write_csr(directed[i].index, directed[i].wdata);
            csr_open = 1'b1;
         end else begin
            if (csr_open) csr_we <= 1'b0;
            csr_open = 1'b0;
            want.qval = directed[i].want_q;
            want.err  = directed[i].want_err;
            send_value(directed[i].value, directed[i].kind == ROW_ITEM_KNOWN, want);
         end
      end

      // random phases, each with its own register setting
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         req_if.valid <= 1'b0;
         wait_drained();
         write_csr(CSR_INV_SCALE, random_inv_scale());
         write_csr(CSR_SCALE_ZERO, 64'($urandom_range(0, 7) == 0));
         write_csr(CSR_OFFSET, random_offset());
         write_csr(CSR_TARGET_TYPE, {$urandom, $urandom});
         csr_we <= 1'b0;
         sender_idles   = ph != 3;
         receiver_idles = ph != 3;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off while beats keep coming
            if (ph == 5 && n == 10) hold_request = 1'b1;
            if (ph == 5 && n == 12) hold_request = 1'b0;
            // sender pause until the pipe has emptied
            if (ph == 7 && n == 70) begin
               req_if.valid <= 1'b0;
               wait_drained();
            end
            send_value(random_single(), 1'b0, want);
         end
      end
      req_if.valid <= 1'b0;

      // drain
      while (pending_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
